// ===== design/lsa_pkg.sv =====
// ----------------------------------------------------------------------------
// lsa_pkg: shared types and constants of the local sequence alignment core
// Score widths, action and direction codes, cell link and score settings.
// ----------------------------------------------------------------------------
package lsa_pkg;

	localparam int SCORE_W = 12;
	localparam int SUM_W = 14;
	localparam logic [SCORE_W-1:0] SCORE_CAP = 12'd4095;

	typedef enum logic [2:0] {
		ACT_CLEAR    = 3'd0,
		ACT_APPEND_A = 3'd1,
		ACT_APPEND_B = 3'd2,
		ACT_ALIGN    = 3'd3,
		ACT_READ     = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		CFG_MATCH    = 2'd0,
		CFG_MISMATCH = 2'd1,
		CFG_GAP      = 2'd2
	} cfg_index_t;

	// traceback move out of a cell, stop marks a zero cell
	typedef enum logic [1:0] {
		DIR_STOP = 2'd0,
		DIR_DIAG = 2'd1,
		DIR_UP   = 2'd2,
		DIR_LEFT = 2'd3
	} dir_t;

	typedef struct packed {
		logic [3:0]        match;
		logic signed [4:0] mismatch;
		logic signed [4:0] gap;
	} score_cfg_t;

	// what one cell hands to the next each cycle
	typedef struct packed {
		logic               vld;
		logic [7:0]         b;
		logic [SCORE_W-1:0] h;
	} link_t;

	function automatic logic [SCORE_W-1:0] clamp_score(input logic signed [SUM_W-1:0] v);
		logic [SCORE_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > $signed({2'b00, SCORE_CAP})) begin
			r = SCORE_CAP;
		end else begin
			r = v[SCORE_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== design/lsa_if.sv =====
// ----------------------------------------------------------------------------
// lsa_if: request and result channels
// Valid/ready channels carrying the request fields and the result fields.
// ----------------------------------------------------------------------------
interface lsa_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [7:0] base;
	logic [8:0] column;
	modport source(output valid, action, base, column, input ready);
	modport sink(input valid, action, base, column, output ready);
endinterface

interface lsa_res_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [11:0] best_score;
	logic [8:0]  end_a;
	logic [8:0]  end_b;
	logic [9:0]  align_length;
	logic [7:0]  col_base_a;
	logic [7:0]  col_base_b;
	logic        gap_in_a;
	logic        gap_in_b;
	modport source(output valid, status, best_score, end_a, end_b, align_length,
		col_base_a, col_base_b, gap_in_a, gap_in_b, input ready);
	modport sink(input valid, status, best_score, end_a, end_b, align_length,
		col_base_a, col_base_b, gap_in_a, gap_in_b, output ready);
endinterface

// ===== design/local_sequence_alignment_core.sv =====
// ----------------------------------------------------------------------------
// local_sequence_alignment_core: local alignment with linear gap cost
// Builds sequences A and B, fills the score matrix in a systolic row of
// cells, traces back the best local alignment and reads it out by column.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                   | handshake
//  req     | in  | action, base, column                      | valid/ready
//  res     | out | status, best_score, end_a, end_b,         | valid/ready
//          |     | align_length, col_base_a/b, gap_in_a/b    |
//  cfg     | in  | cfg_index, cfg_data                       | cfg_we only
//
// clear, append and unused codes answer from idle; a column read passes through
// the read wait and read out states. align loads A into the cells, streams B
// through the row of cells while the row best settles along the chain, then
// traces back one column at a time (the direction RAM read and row select)
// until the trace reaches row or column zero, stops at an inner zero cell or
// fills the column store. reset clears control state only, no clearing pass.
// a new request is taken in idle once the result register is free or being
// drained in the same cycle.
// ----------------------------------------------------------------------------
module local_sequence_alignment_core #(
	parameter int MAX_LEN = 256
) (
	input logic         clk,
	input logic         arst_n,
	lsa_req_if.sink     req,
	lsa_res_if.source   res,
	input logic         cfg_we,
	input logic [1:0]   cfg_index,
	input logic [4:0]   cfg_data
);
	import lsa_pkg::*;

	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int AW = $clog2(MAX_LEN);
	localparam int MAX_COLS = 2 * MAX_LEN;
	localparam int CW = $clog2(MAX_COLS + 1);
	localparam int CAW = $clog2(MAX_COLS);
	localparam int CNTW = $clog2(2 * MAX_LEN + 8);
	localparam int XW = (CW > 9) ? CW : 9;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_RDWAIT = 8'b0000_0010,
		ST_RDOUT  = 8'b0000_0100,
		ST_LOADA  = 8'b0000_1000,
		ST_SWEEP  = 8'b0001_0000,
		ST_TBRD   = 8'b0010_0000,
		ST_TBWAIT = 8'b0100_0000,
		ST_TBDEC  = 8'b1000_0000
	} state_t;

	state_t             state_q;
	score_cfg_t         cfg_q;
	logic [LW-1:0]      la_q, lb_q;
	logic [SCORE_W-1:0] last_score_q, best_q;
	logic [LW-1:0]      last_ea_q, last_eb_q, bi_q, bj_q;
	logic [CW-1:0]      last_len_q, n_q;
	logic [LW-1:0]      tb_i_q, tb_j_q;
	logic [CNTW-1:0]    cnt_q;
	logic               a_vld_s1, b_vld_s1;
	dir_t               dir_s1;
	logic [CAW-1:0]     col_addr_q;
	logic               res_vld_q, status_q;
	logic [17:0]        word_q;

	logic               acc, tb_done;
	logic [LW-1:0]      im1, jm1;
	logic [CNTW-1:0]    a_back;
	logic [AW-1:0]      a_raddr, b_raddr;
	logic [7:0]         a_rd, b_rd;
	logic               a_we, b_we, col_we;
	logic [17:0]        col_wdata, col_rd;
	logic [XW-1:0]      rd_back;

	// chain wiring, index k feeds cell k
	link_t              lnk [MAX_LEN+1];
	logic [7:0]         a_ch [MAX_LEN+1];
	logic [SCORE_W-1:0] run_s [MAX_LEN+1];
	logic [LW-1:0]      run_r [MAX_LEN+1];
	logic [LW-1:0]      run_c [MAX_LEN+1];
	dir_t               dir_rd [MAX_LEN];

	assign req.ready = (state_q == ST_IDLE) && (!res_vld_q || res.ready);
	assign acc = req.valid && req.ready;

	always_comb begin
		im1 = tb_i_q - LW'(1);
		jm1 = tb_j_q - LW'(1);
		a_back = CNTW'(la_q) - cnt_q - CNTW'(1);
		a_raddr = (state_q == ST_LOADA) ? a_back[AW-1:0] : im1[AW-1:0];
		b_raddr = (state_q == ST_SWEEP) ? cnt_q[AW-1:0] : jm1[AW-1:0];
		a_we = acc && (req.action == ACT_APPEND_A) && (la_q < LW'(MAX_LEN));
		b_we = acc && (req.action == ACT_APPEND_B) && (lb_q < LW'(MAX_LEN));
		rd_back = XW'(last_len_q) - XW'(1) - XW'(req.column);
		// traceback ends at row or column zero, at a zero cell, or when full
		tb_done = ((state_q == ST_TBRD) &&
			((tb_i_q == '0) || (tb_j_q == '0) || (n_q == CW'(MAX_COLS)))) ||
			((state_q == ST_TBDEC) && (dir_s1 == DIR_STOP));
		col_we = (state_q == ST_TBDEC) && (dir_s1 != DIR_STOP);
		case (dir_s1)
			DIR_DIAG: col_wdata = {2'b00, b_rd, a_rd};
			DIR_UP:   col_wdata = {2'b10, 8'h00, a_rd};
			DIR_LEFT: col_wdata = {2'b01, b_rd, 8'h00};
			default:  col_wdata = '0;
		endcase
	end

	// sequence stores and the column store
	lsa_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_a_ram (
		.clk(clk), .we(a_we), .waddr(la_q[AW-1:0]), .wdata(req.base),
		.raddr(a_raddr), .rdata(a_rd)
	);

	lsa_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_b_ram (
		.clk(clk), .we(b_we), .waddr(lb_q[AW-1:0]), .wdata(req.base),
		.raddr(b_raddr), .rdata(b_rd)
	);

	lsa_ram #(.WIDTH(18), .DEPTH(MAX_COLS)) u_col_ram (
		.clk(clk), .we(col_we), .waddr(n_q[CAW-1:0]), .wdata(col_wdata),
		.raddr(col_addr_q), .rdata(col_rd)
	);

	// head of the cell row: row zero above, A shifted in from its store
	assign lnk[0].vld = b_vld_s1;
	assign lnk[0].b   = b_rd;
	assign lnk[0].h   = '0;
	assign a_ch[0]    = a_rd;
	assign run_s[0]   = '0;
	assign run_r[0]   = '0;
	assign run_c[0]   = '0;

	for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
		lsa_cell #(.MAX_LEN(MAX_LEN), .ROW(k)) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.clr          (state_q == ST_LOADA),
			.ld           (a_vld_s1),
			.a_in         (a_ch[k]),
			.a_out        (a_ch[k+1]),
			.link_in      (lnk[k]),
			.link_out     (lnk[k+1]),
			.cfg          (cfg_q),
			.la           (la_q),
			.run_score_in (run_s[k]),
			.run_row_in   (run_r[k]),
			.run_col_in   (run_c[k]),
			.run_score_out(run_s[k+1]),
			.run_row_out  (run_r[k+1]),
			.run_col_out  (run_c[k+1]),
			.rd_addr      (jm1[AW-1:0]),
			.dir_rd       (dir_rd[k])
		);
	end

	// score settings, to be written by the user only while idle; the block leaves this unchecked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.match    <= 4'd2;
			cfg_q.mismatch <= 5'b11111;
			cfg_q.gap      <= 5'b11110;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MATCH:    cfg_q.match <= cfg_data[3:0];
				CFG_MISMATCH: cfg_q.mismatch <= cfg_data;
				CFG_GAP:      cfg_q.gap <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			la_q         <= '0;
			lb_q         <= '0;
			last_score_q <= '0;
			last_ea_q    <= '0;
			last_eb_q    <= '0;
			last_len_q   <= '0;
			best_q       <= '0;
			bi_q         <= '0;
			bj_q         <= '0;
			tb_i_q       <= '0;
			tb_j_q       <= '0;
			n_q          <= '0;
			cnt_q        <= '0;
			a_vld_s1     <= 1'b0;
			b_vld_s1     <= 1'b0;
			dir_s1       <= DIR_STOP;
			col_addr_q   <= '0;
			res_vld_q    <= 1'b0;
			status_q     <= 1'b0;
			word_q       <= '0;
		end else begin
			a_vld_s1 <= (state_q == ST_LOADA) && (cnt_q < CNTW'(la_q));
			b_vld_s1 <= (state_q == ST_SWEEP) && (cnt_q < CNTW'(lb_q));
			if (res.ready) begin
				res_vld_q <= 1'b0;
			end

			if (tb_done) begin
				last_score_q <= best_q;
				last_ea_q    <= bi_q;
				last_eb_q    <= bj_q;
				last_len_q   <= n_q;
				status_q     <= 1'b0;
				word_q       <= '0;
				res_vld_q    <= 1'b1;
				state_q      <= ST_IDLE;
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (acc) begin
							status_q <= 1'b0;
							word_q   <= '0;
							case (req.action)
								ACT_CLEAR: begin
									la_q         <= '0;
									lb_q         <= '0;
									last_score_q <= '0;
									last_ea_q    <= '0;
									last_eb_q    <= '0;
									last_len_q   <= '0;
									res_vld_q    <= 1'b1;
								end
								ACT_APPEND_A: begin
									if (a_we) begin
										la_q <= la_q + LW'(1);
									end else begin
										status_q <= 1'b1;
									end
									res_vld_q <= 1'b1;
								end
								ACT_APPEND_B: begin
									if (b_we) begin
										lb_q <= lb_q + LW'(1);
									end else begin
										status_q <= 1'b1;
									end
									res_vld_q <= 1'b1;
								end
								ACT_ALIGN: begin
									cnt_q   <= '0;
									state_q <= ST_LOADA;
								end
								ACT_READ: begin
									// columns are stored last first
									if (XW'(req.column) < XW'(last_len_q)) begin
										col_addr_q <= rd_back[CAW-1:0];
										state_q    <= ST_RDWAIT;
									end else begin
										status_q  <= 1'b1;
										res_vld_q <= 1'b1;
									end
								end
								default: begin
									res_vld_q <= 1'b1;
								end
							endcase
						end
					end
					ST_RDWAIT: begin
						state_q <= ST_RDOUT;
					end
					ST_RDOUT: begin
						status_q  <= 1'b0;
						word_q    <= col_rd;
						res_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
					ST_LOADA: begin
						if (cnt_q == CNTW'(la_q)) begin
							cnt_q   <= '0;
							state_q <= ST_SWEEP;
						end else begin
							cnt_q <= cnt_q + CNTW'(1);
						end
					end
					ST_SWEEP: begin
						// wait for B to leave the last cell and the best to settle
						if (cnt_q == CNTW'(lb_q) + CNTW'(MAX_LEN + 4)) begin
							best_q  <= run_s[MAX_LEN];
							bi_q    <= run_r[MAX_LEN];
							bj_q    <= run_c[MAX_LEN];
							tb_i_q  <= run_r[MAX_LEN];
							tb_j_q  <= run_c[MAX_LEN];
							n_q     <= '0;
							state_q <= ST_TBRD;
						end else begin
							cnt_q <= cnt_q + CNTW'(1);
						end
					end
					ST_TBRD: begin
						state_q <= ST_TBWAIT;
					end
					ST_TBWAIT: begin
						dir_s1  <= dir_rd[im1[AW-1:0]];
						state_q <= ST_TBDEC;
					end
					ST_TBDEC: begin
						n_q <= n_q + CW'(1);
						case (dir_s1)
							DIR_DIAG: begin
								tb_i_q <= im1;
								tb_j_q <= jm1;
							end
							DIR_UP:   tb_i_q <= im1;
							default:  tb_j_q <= jm1;
						endcase
						state_q <= ST_TBRD;
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	assign res.valid        = res_vld_q;
	assign res.status       = status_q;
	assign res.best_score   = last_score_q;
	assign res.end_a        = 9'(last_ea_q);
	assign res.end_b        = 9'(last_eb_q);
	assign res.align_length = 10'(last_len_q);
	assign res.col_base_a   = word_q[7:0];
	assign res.col_base_b   = word_q[15:8];
	assign res.gap_in_a     = word_q[16];
	assign res.gap_in_b     = word_q[17];
endmodule

// ===== design/lsa_ram.sv =====
// ----------------------------------------------------------------------------
// lsa_ram: generic single write port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== design/lsa_cell.sv =====
// ----------------------------------------------------------------------------
// lsa_cell: one row of the score matrix
// Holds one base of A, scores one column per cycle as B passes through,
// keeps its row best and stores the traceback move of every cell of its row.
// ----------------------------------------------------------------------------
module lsa_cell #(
	parameter int MAX_LEN = 256,
	parameter int ROW = 0,
	localparam int LW = $clog2(MAX_LEN + 1),
	localparam int AW = $clog2(MAX_LEN)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       clr,
	input  logic                       ld,
	input  logic [7:0]                 a_in,
	output logic [7:0]                 a_out,
	input  lsa_pkg::link_t             link_in,
	output lsa_pkg::link_t             link_out,
	input  lsa_pkg::score_cfg_t        cfg,
	input  logic [LW-1:0]              la,
	input  logic [lsa_pkg::SCORE_W-1:0] run_score_in,
	input  logic [LW-1:0]              run_row_in,
	input  logic [LW-1:0]              run_col_in,
	output logic [lsa_pkg::SCORE_W-1:0] run_score_out,
	output logic [LW-1:0]              run_row_out,
	output logic [LW-1:0]              run_col_out,
	input  logic [AW-1:0]              rd_addr,
	output lsa_pkg::dir_t              dir_rd
);
	import lsa_pkg::*;

	logic [7:0]              a_q;
	logic [SCORE_W-1:0]      h_left_q, h_diag_q, best_q;
	logic [LW-1:0]           col_q, bcol_q;
	link_t                   link_q;
	logic [SCORE_W-1:0]      run_score_q;
	logic [LW-1:0]           run_row_q, run_col_q;
	logic                    active;
	logic signed [SUM_W-1:0] s, g, d, u, l, m;
	logic [SCORE_W-1:0]      h;
	dir_t                    dir;
	logic [1:0]              dir_raw;

	always_comb begin
		active = LW'(ROW) < la;
		s = (a_q == link_in.b) ? $signed({{(SUM_W-4){1'b0}}, cfg.match})
			: $signed({{(SUM_W-5){cfg.mismatch[4]}}, cfg.mismatch});
		g = $signed({{(SUM_W-5){cfg.gap[4]}}, cfg.gap});
		d = $signed({2'b00, h_diag_q}) + s;
		u = $signed({2'b00, link_in.h}) + g;
		l = $signed({2'b00, h_left_q}) + g;
		m = (d > u) ? d : u;
		m = (m > l) ? m : l;
		h = clamp_score(m);
		// traceback preference: diagonal, then up, then left
		if (h == '0) begin
			dir = DIR_STOP;
		end else if (h == clamp_score(d)) begin
			dir = DIR_DIAG;
		end else if (h == clamp_score(u)) begin
			dir = DIR_UP;
		end else begin
			dir = DIR_LEFT;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			a_q <= a_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_left_q    <= '0;
			h_diag_q    <= '0;
			best_q      <= '0;
			col_q       <= '0;
			bcol_q      <= '0;
			link_q      <= '0;
			run_score_q <= '0;
			run_row_q   <= '0;
			run_col_q   <= '0;
		end else if (clr) begin
			h_left_q    <= '0;
			h_diag_q    <= '0;
			best_q      <= '0;
			col_q       <= '0;
			bcol_q      <= '0;
			link_q      <= '0;
			run_score_q <= '0;
			run_row_q   <= '0;
			run_col_q   <= '0;
		end else begin
			link_q.vld <= link_in.vld;
			link_q.b   <= link_in.b;
			link_q.h   <= h;
			if (link_in.vld) begin
				h_left_q <= h;
				h_diag_q <= link_in.h;
				col_q    <= col_q + LW'(1);
				if (active && (h > best_q)) begin
					best_q <= h;
					bcol_q <= col_q + LW'(1);
				end
			end
			// earlier rows win ties
			if (best_q > run_score_in) begin
				run_score_q <= best_q;
				run_row_q   <= LW'(ROW + 1);
				run_col_q   <= bcol_q;
			end else begin
				run_score_q <= run_score_in;
				run_row_q   <= run_row_in;
				run_col_q   <= run_col_in;
			end
		end
	end

	lsa_ram #(.WIDTH(2), .DEPTH(MAX_LEN)) u_dir_ram (
		.clk  (clk),
		.we   (link_in.vld && active && !clr),
		.waddr(col_q[AW-1:0]),
		.wdata(dir),
		.raddr(rd_addr),
		.rdata(dir_raw)
	);

	assign dir_rd        = dir_t'(dir_raw);
	assign a_out         = a_q;
	assign link_out      = link_q;
	assign run_score_out = run_score_q;
	assign run_row_out   = run_row_q;
	assign run_col_out   = run_col_q;
endmodule
